// ===== hw/rtl/qrs_pkg.sv =====
// ============================================================================
// qrs_pkg
// Shared types and constants of the quadratic root solver.
// ============================================================================
package qrs_pkg;

    localparam int COEF_WIDTH = 16;
    localparam int FRAC_BITS  = 16;
    localparam int ROOT_WIDTH = 34;

    typedef enum logic [1:0] {
        CNT_NONE   = 2'd0,
        CNT_DOUBLE = 2'd1,
        CNT_TWO    = 2'd2,
        CNT_A_ZERO = 2'd3
    } t_count;

endpackage

// ===== hw/rtl/quadratic_root_solver_unit.sv =====
// The pipeline has 3 + (COEF_WIDTH+FRAC_BITS+1) + (COEF_WIDTH+FRAC_BITS+2) + 2 register stages,
// 72 at default.
// Throughput: one item per cycle while the output is not stalled; every unit is a row of digit cells.
// The pipeline advances whenever the output register is free or being taken.
// Reset (i_rst_n low, synchronous) clears all valid bits; data needs none.
// ============================================================================
// quadratic_root_solver_unit
// Real roots of a*x^2+b*x+c in fixed point via chains of sqrt and divide cells.
// ============================================================================
module quadratic_root_solver_unit #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // coef_a, coef_b, coef_c from bit 0 up
    input  logic [((3*COEF_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // root_count[1:0], root_plus[35:2], root_minus[69:36], zero fill
    output logic [71:0]                m_axis_tdata
);
    localparam int CW  = COEF_WIDTH;
    localparam int RW  = qrs_pkg::ROOT_WIDTH;
    localparam int XW  = 2*CW + 2;              // discriminant, signed
    localparam int SR  = XW/2 + FRAC_BITS;      // root bits of sqrt
    localparam int SD  = 2*SR;                  // radicand width
    localparam int NS  = SR;                    // sqrt cells
    localparam int NMW = CW + FRAC_BITS + 2;    // |numerator| width
    localparam int DNW = CW + 1;                // |2a| width
    localparam int QW  = NMW;                   // quotient bits = cells
    localparam int LAT = 3 + NS + QW + 2;

    // pipeline enable: move when the output stage can take an item
    logic w_adv;
    logic [LAT-1:0] r_vld;
    assign w_adv         = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // stages 1 and 2: capture inputs, then form products
    logic signed [CW-1:0] r_a, r_b, r_c;
    logic signed [2*CW-1:0] r_bb, r_ac;
    logic signed [CW-1:0] r_a2, r_b2;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a  <= s_axis_tdata[CW-1:0];
            r_b  <= s_axis_tdata[2*CW-1:CW];
            r_c  <= s_axis_tdata[3*CW-1:2*CW];
            r_bb <= r_b * r_b;
            r_ac <= r_a * r_c;
            r_a2 <= r_a;
            r_b2 <= r_b;
        end
    end

    // stage 3: discriminant, class, signed numerator parts
    logic signed [XW-1:0] r_dl;
    logic signed [CW-1:0] r_a3, r_b3;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dl <= XW'(r_bb) - (XW'(r_ac) <<< 2);
            r_a3 <= r_a2;
            r_b3 <= r_b2;
        end
    end

    localparam int PW = 2 + 2*CW;
    logic [1:0] w_cnt;
    always_comb begin
        if (r_a3 == '0)          w_cnt = qrs_pkg::CNT_A_ZERO;
        else if (r_dl[XW-1])     w_cnt = qrs_pkg::CNT_NONE;
        else if (r_dl == '0)     w_cnt = qrs_pkg::CNT_DOUBLE;
        else                     w_cnt = qrs_pkg::CNT_TWO;
    end

    // sqrt chain
    logic [SD-1:0] w_rad [NS+1];
    logic [SR-1:0] w_rt  [NS+1];
    logic [SR+1:0] w_rm  [NS+1];
    logic [PW-1:0] w_py  [NS+1];
    logic [XW-1:0] w_dl_sq;
    assign w_dl_sq  = (w_cnt == qrs_pkg::CNT_TWO) ? r_dl : '0;
    assign w_rad[0] = SD'(w_dl_sq) << (2*FRAC_BITS);
    assign w_rt[0]  = '0;
    assign w_rm[0]  = '0;
    assign w_py[0]  = {r_b3, r_a3, w_cnt};

    for (genvar g = 0; g < NS; g++) begin : g_sq
        qrs_sqrt_cell #(.RW(SR), .DW(SD), .PW(PW)) u_cell (
            .i_clk(i_clk), .i_en(w_adv),
            .i_rad(w_rad[g]), .i_root(w_rt[g]), .i_rem(w_rm[g]), .i_pay(w_py[g]),
            .o_rad(w_rad[g+1]), .o_root(w_rt[g+1]), .o_rem(w_rm[g+1]),
            .o_pay(w_py[g+1])
        );
    end

    // numerators and divisor, as magnitudes with signs
    logic [1:0] w_qc;
    logic signed [CW-1:0] w_qa, w_qb;
    logic signed [NMW:0] w_nb, w_np, w_nm;
    logic [DNW:0] w_aa;
    assign {w_qb, w_qa, w_qc} = w_py[NS];
    assign w_nb = -((NMW+1)'(w_qb) <<< FRAC_BITS);
    assign w_np = w_nb + (NMW+1)'(w_rt[NS]);
    assign w_nm = w_nb - (NMW+1)'(w_rt[NS]);
    assign w_aa = w_qa[CW-1] ? -(DNW+1)'(w_qa) : (DNW+1)'(w_qa);

    logic [NMW-1:0] r_mp, r_mm;
    logic [DNW-1:0] r_dn;
    logic r_sp, r_sm;
    logic [1:0] r_qc;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mp <= NMW'(w_np[NMW] ? -w_np : w_np);
            r_mm <= NMW'(w_nm[NMW] ? -w_nm : w_nm);
            r_dn <= (w_aa == '0) ? DNW'(1) : DNW'(w_aa << 1);
            r_sp <= w_np[NMW] ^ w_qa[CW-1];
            r_sm <= w_nm[NMW] ^ w_qa[CW-1];
            r_qc <= w_qc;
        end
    end

    // two divider chains sharing one divisor per item
    localparam int DP = 3;
    logic [NMW-1:0] w_pn [QW+1], w_mn [QW+1];
    logic [DNW-1:0] w_pd [QW+1], w_md [QW+1];
    logic [DNW:0]   w_pr [QW+1], w_mr [QW+1];
    logic [DP-1:0]  w_pp [QW+1], w_mp [QW+1];
    assign w_pn[0] = r_mp;
    assign w_mn[0] = r_mm;
    assign w_pd[0] = r_dn;
    assign w_md[0] = r_dn;
    assign w_pr[0] = '0;
    assign w_mr[0] = '0;
    assign w_pp[0] = {r_sp, r_qc};
    assign w_mp[0] = {r_sm, r_qc};

    for (genvar g = 0; g < QW; g++) begin : g_dv
        qrs_div_cell #(.NW(NMW), .DW(DNW), .PW(DP)) u_p (
            .i_clk(i_clk), .i_en(w_adv),
            .i_num(w_pn[g]), .i_den(w_pd[g]), .i_rem(w_pr[g]), .i_pay(w_pp[g]),
            .o_num(w_pn[g+1]), .o_den(w_pd[g+1]), .o_rem(w_pr[g+1]),
            .o_pay(w_pp[g+1])
        );
        qrs_div_cell #(.NW(NMW), .DW(DNW), .PW(DP)) u_m (
            .i_clk(i_clk), .i_en(w_adv),
            .i_num(w_mn[g]), .i_den(w_md[g]), .i_rem(w_mr[g]), .i_pay(w_mp[g]),
            .o_num(w_mn[g+1]), .o_den(w_md[g+1]), .o_rem(w_mr[g+1]),
            .o_pay(w_mp[g+1])
        );
    end

    // output register: apply signs, zero unused roots
    logic [RW-1:0] w_qp, w_qm;
    logic [1:0] w_oc;
    logic w_zero;
    assign w_oc   = w_pp[QW][1:0];
    assign w_zero = (w_oc == qrs_pkg::CNT_NONE) || (w_oc == qrs_pkg::CNT_A_ZERO);
    assign w_qp   = RW'({{RW{1'b0}}, w_pn[QW]});
    assign w_qm   = RW'({{RW{1'b0}}, w_mn[QW]});

    logic [71:0] r_out;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= {2'b00,
                      w_zero ? RW'(0) : (w_mp[QW][2] ? -w_qm : w_qm),
                      w_zero ? RW'(0) : (w_pp[QW][2] ? -w_qp : w_qp),
                      w_oc};
        end
    end
    assign m_axis_tdata  = r_out;
    assign m_axis_tvalid = r_vld[LAT-1];
endmodule

// ===== hw/rtl/qrs_sqrt_cell.sv =====
// ============================================================================
// qrs_sqrt_cell
// One digit step of a pipelined square root: two radicand bits a cycle while i_en is high.
// ============================================================================
module qrs_sqrt_cell #(
    parameter int RW = 32,
    parameter int DW = 64,
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_rad,
    input  logic [RW-1:0] i_root,
    input  logic [RW+1:0] i_rem,
    input  logic [PW-1:0] i_pay,
    output logic [DW-1:0] o_rad,
    output logic [RW-1:0] o_root,
    output logic [RW+1:0] o_rem,
    output logic [PW-1:0] o_pay
);
    logic [RW+1:0] w_rem;
    logic [RW+1:0] w_trial;

    // shift in the top two radicand bits, try the next root bit
    assign w_rem   = {i_rem[RW-1:0], i_rad[DW-1 -: 2]};
    assign w_trial = {i_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rad <= {i_rad[DW-3:0], 2'b00};
            o_pay <= i_pay;
            if (w_rem >= w_trial) begin
                o_rem  <= w_rem - w_trial;
                o_root <= {i_root[RW-2:0], 1'b1};
            end else begin
                o_rem  <= w_rem;
                o_root <= {i_root[RW-2:0], 1'b0};
            end
        end
    end
endmodule

// ===== hw/rtl/qrs_div_cell.sv =====
// ============================================================================
// qrs_div_cell
// One restoring step of a pipelined unsigned divider: one quotient bit.
// ============================================================================
module qrs_div_cell #(
    parameter int NW = 40,
    parameter int DW = 18,
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [DW:0]   i_rem,
    input  logic [PW-1:0] i_pay,
    output logic [NW-1:0] o_num,
    output logic [DW-1:0] o_den,
    output logic [DW:0]   o_rem,
    output logic [PW-1:0] o_pay
);
    logic [DW:0] w_rem;

    // bring down the next numerator bit
    assign w_rem = {i_rem[DW-1:0], i_num[NW-1]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_den <= i_den;
            o_pay <= i_pay;
            if (w_rem >= {1'b0, i_den}) begin
                o_rem <= w_rem - {1'b0, i_den};
                o_num <= {i_num[NW-2:0], 1'b1};
            end else begin
                o_rem <= w_rem;
                o_num <= {i_num[NW-2:0], 1'b0};
            end
        end
    end
endmodule

// ===== hw/rtl/qrs_checker.sv =====
// ============================================================================
// qrs_checker
// Port-level checks of the quadratic root solver.
// ============================================================================
module qrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);
    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // ready follows the output side
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready not tied to output stage");

    // unused roots are zero
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == qrs_pkg::CNT_NONE ||
                          m_axis_tdata[1:0] == qrs_pkg::CNT_A_ZERO)
        |-> m_axis_tdata[69:2] == '0)
        else $error("unused root not zero");

    // double root gives equal roots
    a_dbl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == qrs_pkg::CNT_DOUBLE
        |-> m_axis_tdata[35:2] == m_axis_tdata[69:36])
        else $error("double root differs");
endmodule

bind quadratic_root_solver_unit qrs_checker u_qrs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
